>>> hdl/fem_pkg.sv
// Package with shared types and constants of the free extent manager.
`default_nettype none
package fem_pkg;
   localparam int MAX_EXTENTS_DEF = 64;
   localparam int OFFSET_BITS_DEF = 32;
   localparam int FIELD_BITS = 32;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_OV_PREV = 3'd2;
   localparam logic [2:0] ST_OV_NEXT = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic OP_RELEASE = 1'b0;
   localparam logic OP_CLAIM   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SRCH_PREV,
      S_DECIDE,
      S_SHUP_RD,
      S_SHUP_WR,
      S_SHDN_RD,
      S_SHDN_WR,
      S_APPLY,
      S_APPLY_PREV,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request, clear index
      logic cmp;        // compare read data, advance or stop search
      logic prev;       // capture the entry before the search position
      logic decide;     // evaluate action with prev and next data
      logic rd_prev;    // read entry at index-1 (shift up)
      logic rd_next;    // read entry at index+1 (shift down)
      logic wr_shift;   // write shifted entry, step index
      logic apply;      // write at the search position and update the count
      logic apply_prev; // write the previous entry
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic srch_done;
      logic reject;      // decision: status only, no change
      logic need_up;     // decision: open a hole (insert)
      logic need_down;   // decision: close a hole (remove)
      logic shift_done;
   } sts_type;
endpackage
`default_nettype wire

>>> hdl/fem_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module fem_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> hdl/fem_ctrl.sv
// Controller state machine of the free extent manager.
`default_nettype none
module fem_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output fem_pkg::cmd_type      cmd,
   input  wire fem_pkg::sts_type sts
);
   import fem_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            cmd.cmp = 1'b1;
            if (sts.srch_done) begin
               state_in = S_SRCH_PREV;
            end
         end
         S_SRCH_PREV: begin
            cmd.prev = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.reject) begin
               state_in = S_RESP;
            end else if (sts.need_up) begin
               state_in = S_SHUP_RD;
            end else if (sts.need_down) begin
               state_in = S_SHDN_RD;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_SHUP_RD: begin
            if (sts.shift_done) begin
               state_in = S_APPLY;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_SHUP_WR;
            end
         end
         S_SHUP_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_SHUP_RD;
         end
         S_SHDN_RD: begin
            if (sts.shift_done) begin
               state_in = S_APPLY;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_SHDN_WR;
            end
         end
         S_SHDN_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_SHDN_RD;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_APPLY_PREV;
         end
         S_APPLY_PREV: begin
            cmd.apply_prev = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("accepting while a response is pending");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.apply, cmd.apply_prev, cmd.wr_shift, cmd.load}))
      else $error("conflicting datapath commands");
endmodule
`default_nettype wire

>>> hdl/fem_dpath.sv
// Datapath of the free extent manager: extent memories, search and update.
`default_nettype none
module fem_dpath #(
   parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF,
   parameter int OFFSET_BITS = fem_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_op,
   input  wire logic [fem_pkg::FIELD_BITS-1:0] req_start,
   input  wire logic [fem_pkg::FIELD_BITS-1:0] req_length,
   input  wire fem_pkg::cmd_type            cmd,
   output fem_pkg::sts_type                 sts,
   output logic [2:0]                       status
);
   import fem_pkg::*;

   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int OB = OFFSET_BITS;
   localparam logic [OB-1:0] OMAX = '1;

   // Entry storage: one start RAM and one length RAM share address and enables.
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [OB-1:0] wr_s, wr_l, rd_s, rd_l;

   fem_ram #(.WIDTH(OB), .DEPTH(MAX_EXTENTS)) u_start_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_s),
      .rd_addr(rd_addr), .rd_data(rd_s));
   fem_ram #(.WIDTH(OB), .DEPTH(MAX_EXTENTS)) u_len_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_l),
      .rd_addr(rd_addr), .rd_data(rd_l));

   function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
                                             input logic [OB-1:0] b);
      logic [OB:0] t;
      t = {1'b0, a} + {1'b0, b};
      sat_add = t[OB] ? OMAX : t[OB-1:0];
   endfunction

   logic          op_ff;
   logic [OB-1:0] s_ff, l_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;       // search index / shift cursor
   logic [CW-1:0] pos_ff, pos_in;
   logic [OB-1:0] ps_ff, pl_ff, ns_ff, nl_ff;   // previous and next entry
   logic          has_prev_ff;
   logic [2:0]    status_ff, status_in;
   // Decided action, held for the apply steps.
   logic          up_ff, down_ff;
   logic          wp_ff, wn_ff, wi_ff;   // write prev, write next, write insert
   logic [OB-1:0] wp_l_ff, wn_s_ff, wn_l_ff, wi_s_ff, wi_l_ff;

   logic [CW-1:0] prev_idx, next_idx, pidx;
   assign prev_idx = idx_ff - 1'b1;
   assign next_idx = idx_ff + 1'b1;
   assign pidx     = pos_ff - 1'b1;

   // Search runs upward one entry per cycle; the entry at idx is on the read
   // port while the read of idx+1 is issued.
   logic          cmp_hit;
   assign cmp_hit = (idx_ff >= count_ff) || (rd_s >= s_ff);

   // Decision logic on captured prev/next.
   logic          has_next;
   logic [OB-1:0] gap_p, gap_n;
   logic          tail_fits, dup;
   always_comb begin
      has_next  = pos_ff < count_ff;
      gap_p     = s_ff - ps_ff;
      gap_n     = ns_ff - s_ff;
      tail_fits = l_ff <= (OMAX - s_ff);
      dup       = has_next && (ns_ff == s_ff);
   end

   logic          d_reject, d_up, d_down, d_wp, d_wn, d_wi;
   logic [OB-1:0] d_wp_l, d_wn_s, d_wn_l, d_wi_s, d_wi_l;
   logic [2:0]    d_status;
   logic [OB-1:0] e_tail;
   always_comb begin
      d_reject = 1'b0; d_up = 1'b0; d_down = 1'b0;
      d_wp = 1'b0; d_wn = 1'b0; d_wi = 1'b0;
      d_wp_l = pl_ff; d_wn_s = ns_ff; d_wn_l = nl_ff;
      d_wi_s = s_ff; d_wi_l = l_ff;
      d_status = ST_OK;
      e_tail = pl_ff - gap_p - l_ff;
      if (op_ff == OP_RELEASE) begin
         if (dup) begin
            d_reject = 1'b1; d_status = ST_DUP;
         end else if (count_ff >= CW'(MAX_EXTENTS)) begin
            d_reject = 1'b1; d_status = ST_FULL;
         end else if (has_prev_ff && pl_ff > gap_p) begin
            d_reject = 1'b1; d_status = ST_OV_PREV;
         end else if (has_next && l_ff > gap_n) begin
            d_reject = 1'b1; d_status = ST_OV_NEXT;
         end else if (has_prev_ff && pl_ff == gap_p) begin
            d_wp = 1'b1;
            if (has_next && l_ff == gap_n) begin
               d_wp_l = sat_add(sat_add(pl_ff, l_ff), nl_ff);
               d_down = 1'b1;
            end else begin
               d_wp_l = sat_add(pl_ff, l_ff);
            end
         end else if (has_next && l_ff == gap_n) begin
            d_wn = 1'b1; d_wn_s = s_ff; d_wn_l = sat_add(l_ff, nl_ff);
         end else begin
            d_up = 1'b1; d_wi = 1'b1;
         end
      end else begin
         if (l_ff == '0) begin
            d_reject = 1'b1;
         end else if (dup) begin
            if (nl_ff > l_ff && tail_fits) begin
               d_wn = 1'b1; d_wn_s = s_ff + l_ff; d_wn_l = nl_ff - l_ff;
            end else begin
               d_down = 1'b1;
            end
         end else if (!has_prev_ff) begin
            d_reject = 1'b1;
         end else if (pl_ff > gap_p) begin
            if ((pl_ff - gap_p) > l_ff && tail_fits) begin
               if (count_ff >= CW'(MAX_EXTENTS)) begin
                  d_reject = 1'b1; d_status = ST_FULL;
               end else begin
                  d_up = 1'b1; d_wi = 1'b1;
                  d_wi_s = s_ff + l_ff; d_wi_l = e_tail;
               end
            end
            if (!d_reject) begin
               d_wp = 1'b1; d_wp_l = gap_p;
            end
         end
      end
   end

   // Shift cursor: up moves entries [pos, count) up by one from the top;
   // down moves entries (pos, count) down by one.
   logic shift_done;
   assign shift_done = up_ff ? (idx_ff <= pos_ff) : (next_idx >= count_ff);

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      if (cmd.rd_prev) begin
         rd_addr = prev_idx[AW-1:0];
      end else if (cmd.rd_next) begin
         rd_addr = next_idx[AW-1:0];
      end else if (cmd.cmp) begin
         // On a hit fetch the entry before the hit, else the next candidate.
         if (cmp_hit) begin
            rd_addr = prev_idx[AW-1:0];
         end else begin
            rd_addr = next_idx[AW-1:0];
         end
      end
   end

   // Write port: shift writes, then the entry at the search position, then
   // the previous entry in the following cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_s    = rd_s;
      wr_l    = rd_l;
      if (cmd.wr_shift) begin
         wr_en = 1'b1;
      end else if (cmd.apply) begin
         if (wi_ff) begin
            wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_s = wi_s_ff; wr_l = wi_l_ff;
         end else if (wn_ff) begin
            wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_s = wn_s_ff; wr_l = wn_l_ff;
         end
      end else if (cmd.apply_prev && wp_ff) begin
         wr_en = 1'b1; wr_addr = pidx[AW-1:0]; wr_s = ps_ff; wr_l = wp_l_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.apply) begin
         if (up_ff) count_in = count_ff + 1'b1;
         else if (down_ff) count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.cmp) begin
         if (cmp_hit) begin
            pos_in = idx_ff;
         end else begin
            idx_in = next_idx;
         end
      end else if (cmd.decide) begin
         status_in = d_status;
         idx_in    = d_up ? count_ff : pos_ff;
      end else if (cmd.wr_shift) begin
         idx_in = up_ff ? prev_idx : next_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      if (cmd.load) begin
         op_ff <= req_op;
         s_ff  <= OB'(req_start);
         l_ff  <= OB'(req_length);
      end
      if (cmd.cmp && cmp_hit) begin
         ns_ff <= rd_s; nl_ff <= rd_l;
      end
      if (cmd.prev) begin
         has_prev_ff <= pos_ff != '0;
         ps_ff <= rd_s; pl_ff <= rd_l;
      end
      if (cmd.decide) begin
         up_ff <= d_up; down_ff <= d_down;
         wp_ff <= d_wp; wn_ff <= d_wn; wi_ff <= d_wi;
         wp_l_ff <= d_wp_l; wn_s_ff <= d_wn_s; wn_l_ff <= d_wn_l;
         wi_s_ff <= d_wi_s; wi_l_ff <= d_wi_l;
      end
   end

   assign sts.srch_done  = cmp_hit;
   assign sts.reject     = d_reject;
   assign sts.need_up    = d_up;
   assign sts.need_down  = d_down;
   assign sts.shift_done = shift_done;
   assign status         = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EXTENTS))
      else $error("extent count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply && up_ff |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table");
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply_prev && wp_ff |-> pos_ff != '0)
      else $error("previous entry written without a previous entry");
endmodule
`default_nettype wire

>>> hdl/free_extent_manager_core.sv
// Top level of the free extent manager: controller plus datapath.
// Each request is handled one at a time. The accepting cycle is followed by
// a read step, a linear search over the sorted table at one entry per
// cycle up to pos, the first entry whose start is not below the request
// start (at most the entry count), a fetch of the entry before that position
// and a decision step. A rejected request then goes straight to the
// response. An insert or a removal shifts the entries behind the position,
// one read and one write per moved entry plus a closing check, through the
// read port and the write port of the extent RAMs, and every update ends
// with an apply step for the entry at the position and an apply_prev step
// for the entry before it; each writes only when the decision asks for it.
// rsp_tready can hold off the response word; no new request is taken until
// the response word is taken.
`default_nettype none
module free_extent_manager_core #(
   parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF,
   parameter int OFFSET_BITS = fem_pkg::OFFSET_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // region_start[31:0], region_length[63:32]
   input  wire logic        req_tuser,   // op: 0 release, 1 claim
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // status[2:0], zero above
);
   import fem_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [2:0] status;

   fem_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .cmd(cmd), .sts(sts));

   fem_dpath #(.MAX_EXTENTS(MAX_EXTENTS), .OFFSET_BITS(OFFSET_BITS)) u_dpath (
      .clock(clock), .reset(reset), .req_op(req_tuser),
      .req_start(req_tdata[31:0]), .req_length(req_tdata[63:32]),
      .cmd(cmd), .sts(sts), .status(status));

   assign rsp_tdata = {5'b0, status};
endmodule
`default_nettype wire
